### rtl/brf_pkg.sv
`timescale 1ns / 1ps
// brf_pkg: widths, codes, state and handshake types, and the edge mask table
// shared by the bitplane rectangle fill modules. No dependencies.
package brf_pkg;

    localparam int STORE_WORDS_DEF = 4096;
    localparam int COORD_W         = 16;
    localparam int PITCH_W         = 8;
    localparam int WADDR_W         = 12;
    localparam int WORD_W          = 16;
    localparam int FUNC_W          = 2;
    localparam int STATUS_W        = 2;
    localparam int CFG_IDX_W       = 3;
    localparam int WORDS_W         = 13;
    localparam int ROWS_W          = 16;
    localparam int SEL_W           = 5;
    localparam int BASE_W          = 25;

    typedef enum logic [FUNC_W-1:0] {
        FN_FILL  = 2'd0,
        FN_READ  = 2'd1,
        FN_WRITE = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BOUNDS = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP    = 3'd0,
        CFG_LEFT   = 3'd1,
        CFG_BOTTOM = 3'd2,
        CFG_RIGHT  = 3'd3,
        CFG_PITCH  = 3'd4
    } t_cfg_reg;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_SETUP,
        S_ROW,
        S_RD,
        S_WR,
        S_NROW,
        S_WORD_RD,
        S_WORD_TAKE,
        S_WORD_WR,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic clear;
        logic capture;
        logic check;
        logic setup;
        logic row_start;
        logic rd_fill;
        logic wr_fill;
        logic word_next;
        logic row_next;
        logic rd_word;
        logic rd_take;
        logic wr_word;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic fill_rejected;
        logic base_in;
        logic addr_in;
        logic last_word;
        logic last_row;
    } t_dp_stat;

    function automatic logic [WORD_W-1:0] edge_mask(input logic [SEL_W-1:0] sel);
        logic [WORD_W-1:0] m;
        unique case (sel)
            5'd1:    m = 16'h0100;
            5'd2:    m = 16'h0300;
            5'd3:    m = 16'h0700;
            5'd4:    m = 16'h0f00;
            5'd5:    m = 16'h1f00;
            5'd6:    m = 16'h3f00;
            5'd7:    m = 16'h7f00;
            5'd8:    m = 16'hff00;
            5'd9:    m = 16'hff01;
            5'd10:   m = 16'hff03;
            5'd11:   m = 16'hff07;
            5'd12:   m = 16'hff0f;
            5'd13:   m = 16'hff1f;
            5'd14:   m = 16'hff3f;
            5'd15:   m = 16'hff7f;
            5'd16:   m = 16'hffff;
            5'd17:   m = 16'hffff;
            default: m = 16'h0000;
        endcase
        return m;
    endfunction

endpackage

### rtl/brf_ram.sv
`timescale 1ns / 1ps
// brf_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module brf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/brf_ctrl.sv
`timescale 1ns / 1ps
// brf_ctrl: sequencing state machine for clear, fill, word read and word write.
// Depends on brf_pkg; drives the brf_dp command struct.
module brf_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [brf_pkg::FUNC_W-1:0]   i_func,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  brf_pkg::t_dp_stat            i_stat,
    output brf_pkg::t_dp_cmd             o_cmd
);
    import brf_pkg::*;

    t_state  r_state;
    t_state  n_state;
    logic    r_out_valid;
    logic    n_out_valid;
    logic    c_accept;
    logic    c_out_free;
    t_dp_cmd c_cmd;

    assign c_accept   = i_in_valid && (r_state == S_IDLE);
    assign c_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (c_accept) begin
                    unique case (i_func)
                        FN_FILL:  n_state = S_CHECK;
                        FN_READ:  n_state = S_WORD_RD;
                        FN_WRITE: n_state = S_WORD_WR;
                        default:  n_state = S_FINISH;
                    endcase
                end
            end
            S_CHECK:     n_state = S_SETUP;
            S_SETUP:     n_state = i_stat.fill_rejected ? S_FINISH : S_ROW;
            S_ROW:       n_state = i_stat.base_in ? S_RD : S_FINISH;
            S_RD:        n_state = i_stat.addr_in ? S_WR : S_NROW;
            S_WR:        n_state = i_stat.last_word ? S_NROW : S_RD;
            S_NROW:      n_state = i_stat.last_row ? S_FINISH : S_ROW;
            S_WORD_RD:   n_state = S_WORD_TAKE;
            S_WORD_TAKE: n_state = S_FINISH;
            S_WORD_WR:   n_state = S_FINISH;
            S_FINISH: begin
                if (c_out_free) n_state = S_IDLE;
            end
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        c_cmd = '0;
        unique case (r_state)
            S_CLEAR:     c_cmd.clear = 1'b1;
            S_IDLE:      c_cmd.capture = c_accept;
            S_CHECK:     c_cmd.check = 1'b1;
            S_SETUP:     c_cmd.setup = 1'b1;
            S_ROW:       c_cmd.row_start = i_stat.base_in;
            S_RD:        c_cmd.rd_fill = i_stat.addr_in;
            S_WR: begin
                c_cmd.wr_fill   = 1'b1;
                c_cmd.word_next = !i_stat.last_word;
            end
            S_NROW:      c_cmd.row_next = !i_stat.last_row;
            S_WORD_RD:   c_cmd.rd_word = 1'b1;
            S_WORD_TAKE: c_cmd.rd_take = 1'b1;
            S_WORD_WR:   c_cmd.wr_word = 1'b1;
            S_FINISH:    c_cmd.load_out = c_out_free;
            default:     c_cmd = '0;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (c_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = c_cmd;

`ifndef NO_ASSERTIONS
    ap_wr_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> ($past(r_state) == S_RD))
        else $error("fill write without preceding read");

    ap_result_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_FINISH))
        else $error("result raised outside finish");
`endif

endmodule

### rtl/brf_dp.sv
`timescale 1ns / 1ps
// brf_dp: configuration registers, rectangle checks, mask and address setup,
// row/word walk and the bitmap store. Depends on brf_pkg and brf_ram.
module brf_dp #(
    parameter int STORE_WORDS = brf_pkg::STORE_WORDS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  brf_pkg::t_dp_cmd               i_cmd,
    output brf_pkg::t_dp_stat              o_stat,
    input  logic                           i_cfg_we,
    input  logic [brf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [brf_pkg::COORD_W-1:0]    i_cfg_data,
    input  logic signed [brf_pkg::COORD_W-1:0] i_rect_top,
    input  logic signed [brf_pkg::COORD_W-1:0] i_rect_left,
    input  logic signed [brf_pkg::COORD_W-1:0] i_rect_bottom,
    input  logic signed [brf_pkg::COORD_W-1:0] i_rect_right,
    input  logic [brf_pkg::WADDR_W-1:0]    i_word_address,
    input  logic [brf_pkg::WORD_W-1:0]     i_word_value,
    output logic [brf_pkg::STATUS_W-1:0]   o_status,
    output logic [brf_pkg::WORD_W-1:0]     o_read_data
);
    import brf_pkg::*;

    localparam int AW = $clog2(STORE_WORDS);

    logic signed [COORD_W-1:0] r_bnd_top;
    logic signed [COORD_W-1:0] r_bnd_left;
    logic signed [COORD_W-1:0] r_bnd_bottom;
    logic signed [COORD_W-1:0] r_bnd_right;
    logic [PITCH_W-1:0]        r_pitch;

    logic signed [COORD_W-1:0] r_top;
    logic signed [COORD_W-1:0] r_left;
    logic signed [COORD_W-1:0] r_bottom;
    logic signed [COORD_W-1:0] r_right;
    logic [WADDR_W-1:0]        r_waddr;
    logic [WORD_W-1:0]         r_wval;

    logic [COORD_W-1:0]        r_width;
    logic [COORD_W-1:0]        r_height;
    logic [COORD_W-1:0]        r_row0;
    logic [COORD_W-1:0]        r_rel_left;
    logic [3:0]                r_endlo;

    logic [WORD_W-1:0]         r_lmask;
    logic [WORD_W-1:0]         r_rmask;
    logic [WORDS_W-1:0]        r_words;
    logic [ROWS_W-1:0]         r_rows;
    logic [BASE_W-1:0]         r_base;
    logic [BASE_W-1:0]         r_addr;
    logic [WORDS_W-1:0]        r_k;

    t_status                   r_res_status;
    logic [WORD_W-1:0]         r_res_data;
    logic [STATUS_W-1:0]       r_status;
    logic [WORD_W-1:0]         r_read_data;
    logic [AW-1:0]             r_clr;

    logic [COORD_W:0]          c_w17;
    logic [COORD_W:0]          c_h17;
    logic                      c_empty;
    logic                      c_oob;
    t_status                   c_chk_status;
    logic [SEL_W-1:0]          c_endp;
    logic [SEL_W-1:0]          c_startp;
    logic [WORD_W-1:0]         c_rmask;
    logic [WORD_W-1:0]         c_lmask;
    logic                      c_single;
    logic [COORD_W-1:0]        c_diff;
    logic [WORDS_W-1:0]        c_words;
    logic [COORD_W+PITCH_W-1:0] c_prod;
    logic [BASE_W-1:0]         c_base;
    logic [ROWS_W-1:0]         c_rows;
    logic [BASE_W-1:0]         c_waddr_ext;
    logic                      c_waddr_in;
    logic                      c_addr_in;
    logic                      c_last_word;
    logic [WORD_W-1:0]         c_mask;

    logic                      c_we;
    logic [AW-1:0]             c_wa;
    logic [WORD_W-1:0]         c_wd;
    logic                      c_re;
    logic [AW-1:0]             c_ra;
    logic [WORD_W-1:0]         c_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bnd_top    <= 16'sd0;
            r_bnd_left   <= 16'sd0;
            r_bnd_bottom <= 16'sd146;
            r_bnd_right  <= 16'sd448;
            r_pitch      <= 8'd28;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TOP:    r_bnd_top    <= i_cfg_data;
                CFG_LEFT:   r_bnd_left   <= i_cfg_data;
                CFG_BOTTOM: r_bnd_bottom <= i_cfg_data;
                CFG_RIGHT:  r_bnd_right  <= i_cfg_data;
                CFG_PITCH:  r_pitch      <= i_cfg_data[PITCH_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        c_w17   = {r_right[COORD_W-1], r_right} - {r_left[COORD_W-1], r_left};
        c_h17   = {r_bottom[COORD_W-1], r_bottom} - {r_top[COORD_W-1], r_top};
        c_empty = c_w17[COORD_W] || (c_w17 == '0) || c_h17[COORD_W] || (c_h17 == '0);
        c_oob   = (r_top < r_bnd_top) || (r_bnd_bottom <= r_top) ||
                  (r_bnd_bottom < r_bottom) || (r_left < r_bnd_left) ||
                  (r_bnd_right <= r_left) || (r_bnd_right < r_right);
        if (c_empty) begin
            c_chk_status = ST_EMPTY;
        end else if (c_oob) begin
            c_chk_status = ST_BOUNDS;
        end else begin
            c_chk_status = ST_OK;
        end
    end

    always_comb begin
        c_endp   = 5'd16 - {1'b0, r_endlo};
        c_startp = 5'd17 - {1'b0, r_rel_left[3:0]};
        c_rmask  = ~edge_mask(c_endp);
        c_lmask  = edge_mask(c_startp);
        c_single = (r_width <= {11'd0, c_startp});
        c_diff   = r_width - {11'd0, c_startp} - 16'd1;
        c_words  = c_single ? WORDS_W'(1) : ({1'b0, c_diff[COORD_W-1:4]} + WORDS_W'(2));
        c_prod   = r_row0 * r_pitch;
        c_base   = BASE_W'(c_prod) + BASE_W'(r_rel_left[COORD_W-1:4]);
        c_rows   = (r_pitch == '0) ? ROWS_W'(1) : r_height;
    end

    assign c_waddr_ext = BASE_W'(r_waddr);
    assign c_waddr_in  = (c_waddr_ext < BASE_W'(STORE_WORDS));
    assign c_addr_in   = (r_addr < BASE_W'(STORE_WORDS));
    assign c_last_word = (r_k == (r_words - WORDS_W'(1)));

    always_comb begin
        if (r_k == '0) begin
            c_mask = r_lmask;
        end else if (c_last_word) begin
            c_mask = r_rmask;
        end else begin
            c_mask = '1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_top    <= i_rect_top;
            r_left   <= i_rect_left;
            r_bottom <= i_rect_bottom;
            r_right  <= i_rect_right;
            r_waddr  <= i_word_address;
            r_wval   <= i_word_value;
        end
        if (i_cmd.check) begin
            r_width    <= c_w17[COORD_W-1:0];
            r_height   <= c_h17[COORD_W-1:0];
            r_row0     <= r_top - r_bnd_top;
            r_rel_left <= r_left - r_bnd_left;
            r_endlo    <= r_right[3:0] - r_bnd_left[3:0] - 4'd1;
        end
        if (i_cmd.setup) begin
            r_lmask <= c_single ? (c_lmask & c_rmask) : c_lmask;
            r_rmask <= c_rmask;
            r_words <= c_words;
            r_rows  <= c_rows;
            r_base  <= c_base;
        end
        if (i_cmd.row_start) begin
            r_addr <= r_base;
            r_k    <= '0;
        end else if (i_cmd.word_next) begin
            r_addr <= r_addr + BASE_W'(1);
            r_k    <= r_k + WORDS_W'(1);
        end
        if (i_cmd.row_next) begin
            r_base <= r_base + BASE_W'(r_pitch);
            r_rows <= r_rows - ROWS_W'(1);
        end
        if (i_cmd.capture) begin
            r_res_status <= ST_OK;
            r_res_data   <= '0;
        end else if (i_cmd.check) begin
            r_res_status <= c_chk_status;
        end else if (i_cmd.rd_take) begin
            r_res_data <= c_waddr_in ? c_rdata : '0;
        end
        if (i_cmd.load_out) begin
            r_status    <= r_res_status;
            r_read_data <= r_res_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear) begin
            r_clr <= r_clr + AW'(1);
        end
    end

    always_comb begin
        c_we = 1'b0;
        c_wa = r_addr[AW-1:0];
        c_wd = c_rdata | c_mask;
        priority if (i_cmd.clear) begin
            c_we = 1'b1;
            c_wa = r_clr;
            c_wd = '0;
        end else if (i_cmd.wr_word) begin
            c_we = c_waddr_in;
            c_wa = c_waddr_ext[AW-1:0];
            c_wd = r_wval;
        end else if (i_cmd.wr_fill) begin
            c_we = 1'b1;
        end else begin
            c_we = 1'b0;
        end
        c_re = i_cmd.rd_fill || (i_cmd.rd_word && c_waddr_in);
        c_ra = i_cmd.rd_word ? c_waddr_ext[AW-1:0] : r_addr[AW-1:0];
    end

    brf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (c_wa),
        .i_wdata (c_wd),
        .i_re    (c_re),
        .i_raddr (c_ra),
        .o_rdata (c_rdata)
    );

    assign o_stat.clr_last      = (r_clr == AW'(STORE_WORDS - 1));
    assign o_stat.fill_rejected = (r_res_status != ST_OK);
    assign o_stat.base_in       = (r_base < BASE_W'(STORE_WORDS));
    assign o_stat.addr_in       = c_addr_in;
    assign o_stat.last_word     = c_last_word;
    assign o_stat.last_row      = (r_rows == ROWS_W'(1));

    assign o_status    = r_status;
    assign o_read_data = r_read_data;

`ifndef NO_ASSERTIONS
    ap_fill_in_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_fill |-> c_addr_in)
        else $error("fill write outside store");

    ap_fill_read_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_fill |-> $past(i_cmd.rd_fill))
        else $error("fill write without read data");

    ap_row_status_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.row_start |-> (r_res_status == ST_OK && r_words != '0))
        else $error("row walk on rejected fill");
`endif

endmodule

### rtl/bitplane_rectangle_fill_top.sv
`timescale 1ns / 1ps
// Bitplane rectangle fill: monochrome 16-bit-word bitmap store with rectangle
// fill, word read and word write. Depends on brf_pkg, brf_ctrl and brf_dp.
//
// Usage:
//   Requests enter on i_in_valid/o_in_ready with i_func selecting fill, word
//   read or word write. Every request yields one result on o_out_valid /
//   i_out_ready carrying o_status and o_read_data.
//   Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at
//   once; the user issues them only while idle, the block does not enforce it.
// Sequence (accept to result valid):
//   a word write writes the store and a word read reads it; a fill is checked
//   and set up, then, unless rejected, walked row by row.
//   Each covered word is read and then written back to the store.
// Reset:
//   Configuration and control registers return to their defaults, then a
//   clearing pass zeroes all STORE_WORDS words (4096 by default) one word a
//   cycle; o_in_ready is low until it ends.
// Stall:
//   One result register sits on the output; the next request is taken while a
//   result waits, and its own result holds in the block until the slot frees.
module bitplane_rectangle_fill_top #(
    parameter int STORE_WORDS = brf_pkg::STORE_WORDS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [brf_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [brf_pkg::COORD_W-1:0] i_rect_top,
    input  logic signed [brf_pkg::COORD_W-1:0] i_rect_left,
    input  logic signed [brf_pkg::COORD_W-1:0] i_rect_bottom,
    input  logic signed [brf_pkg::COORD_W-1:0] i_rect_right,
    input  logic [brf_pkg::WADDR_W-1:0]        i_word_address,
    input  logic [brf_pkg::WORD_W-1:0]         i_word_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [brf_pkg::STATUS_W-1:0]       o_status,
    output logic [brf_pkg::WORD_W-1:0]         o_read_data,
    input  logic                               i_cfg_we,
    input  logic [brf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [brf_pkg::COORD_W-1:0]        i_cfg_data
);
    import brf_pkg::*;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    brf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_func      (i_func),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    brf_dp #(
        .STORE_WORDS (STORE_WORDS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_rect_top     (i_rect_top),
        .i_rect_left    (i_rect_left),
        .i_rect_bottom  (i_rect_bottom),
        .i_rect_right   (i_rect_right),
        .i_word_address (i_word_address),
        .i_word_value   (i_word_value),
        .o_status       (o_status),
        .o_read_data    (o_read_data)
    );

endmodule
